// File: sv/cswc_pkg.sv
package cswc_pkg;

  localparam int unsigned TIME_W  = 30;
  localparam int unsigned SAT_W   = 8;
  localparam int unsigned SLIP_W  = 16;
  localparam int unsigned SUM_W   = 22;

  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [TIME_W-1:0] WINDOW_RESET  = 30'd60000;

  localparam logic REQ_FEED  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] time_ms;
    logic [SAT_W-1:0]  sat_index;
    logic [SLIP_W-1:0] slip_count;
  } req_t;

  typedef struct packed {
    logic [SUM_W-1:0] slip_sum;
    logic             first_seen;
    logic             hit_added;
    logic             hit_dropped;
  } rsp_t;

endpackage

// File: sv/cswc_ram.sv
module cswc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cycle_slip_window_counter.sv
// Channel   Direction  Payload               Handshake
// req       in         cswc_pkg::req_t       req_valid / req_ready
// rsp       out        cswc_pkg::rsp_t       rsp_valid / rsp_ready
// cfg       in         window length, 30 b   cfg_we, no wait
//
// A feed goes through baseline read, check with write-back, and result; the check is
// skipped when the satellite is out of range. A query reads one hit slot a cycle and
// compacts the kept hits in place.
// After reset the baseline memory is cleared before any request is accepted.
// While a result waits to be taken, the next request stops in its result state.
module cycle_slip_window_counter #(
  parameter int unsigned SAT_COUNT = 256,
  parameter int unsigned HIT_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  cswc_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output cswc_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [cswc_pkg::TIME_W-1:0]     cfg_wdata
);

  import cswc_pkg::*;

  localparam int unsigned SAT_AW = $clog2(SAT_COUNT);
  localparam int unsigned HIT_AW = $clog2(HIT_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HIT_DEPTH + 1);
  localparam int unsigned BASE_W = SLIP_W + 1;
  localparam int unsigned HIT_W  = TIME_W + SLIP_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FCHK  = 3'd2;
  localparam logic [2:0] ST_QRUN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;
  logic [SAT_AW-1:0] clr_idx;
  logic [TIME_W-1:0] window_length;
  req_t              cur;
  rsp_t              res;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  keep_cnt;
  logic              pend;

  logic              base_we;
  logic [SAT_AW-1:0] base_waddr;
  logic [BASE_W-1:0] base_wdata;
  logic [SAT_AW-1:0] base_raddr;
  logic [BASE_W-1:0] base_rdata;

  logic              hit_we;
  logic [HIT_AW-1:0] hit_waddr;
  logic [HIT_W-1:0]  hit_wdata;
  logic [HIT_W-1:0]  hit_rdata;

  logic              accept;
  logic              in_range;
  logic              seen;
  logic [SLIP_W-1:0] last_slip;
  logic              rising;
  logic              has_room;
  logic [TIME_W-1:0] rd_time;
  logic [SLIP_W-1:0] rd_delta;
  logic              keep_hit;
  logic [SUM_W:0]    sum_ext;
  logic              rsp_load;

  cswc_ram #(.WIDTH(BASE_W), .DEPTH(SAT_COUNT)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_waddr),
    .wdata (base_wdata),
    .raddr (base_raddr),
    .rdata (base_rdata)
  );

  cswc_ram #(.WIDTH(HIT_W), .DEPTH(HIT_DEPTH)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (hit_waddr),
    .wdata (hit_wdata),
    .raddr (rd_idx[HIT_AW-1:0]),
    .rdata (hit_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign in_range  = 32'(cur.sat_index) < SAT_COUNT;
  assign base_raddr = SAT_AW'(req.sat_index);

  assign seen      = base_rdata[SLIP_W];
  assign last_slip = base_rdata[SLIP_W-1:0];
  assign rising    = cur.slip_count > last_slip;
  assign has_room  = occ < CNT_W'(HIT_DEPTH);

  assign rd_time  = hit_rdata[HIT_W-1:SLIP_W];
  assign rd_delta = hit_rdata[SLIP_W-1:0];
  assign keep_hit = !(({1'b0, rd_time} + {1'b0, window_length}) < {1'b0, cur.time_ms});
  assign sum_ext  = {1'b0, res.slip_sum} + (SUM_W+1)'(rd_delta);
  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    base_we    = 1'b0;
    base_waddr = SAT_AW'(cur.sat_index);
    base_wdata = {1'b1, cur.slip_count};
    hit_we     = 1'b0;
    hit_waddr  = occ[HIT_AW-1:0];
    hit_wdata  = {cur.time_ms, cur.slip_count - last_slip};
    unique case (state)
      ST_CLEAR: begin
        base_we    = 1'b1;
        base_waddr = clr_idx;
        base_wdata = '0;
      end
      ST_FCHK: begin
        base_we = 1'b1;
        hit_we  = seen && rising && has_room;
      end
      ST_QRUN: begin
        hit_we    = pend && keep_hit;
        hit_waddr = keep_cnt[HIT_AW-1:0];
        hit_wdata = hit_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      window_length <= WINDOW_RESET;
      occ           <= '0;
      rd_idx        <= '0;
      keep_cnt      <= '0;
      pend          <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SAT_AW'(1);
          if (clr_idx == SAT_AW'(SAT_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_idx   <= '0;
            keep_cnt <= '0;
            pend     <= 1'b0;
            if (req.req_type == REQ_QUERY) begin
              state <= ST_QRUN;
            end else if (32'(req.sat_index) < SAT_COUNT) begin
              state <= ST_FCHK;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_FCHK: begin
          if (seen && rising && has_room) begin
            occ <= occ + CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_QRUN: begin
          if (rd_idx < occ) begin
            rd_idx <= rd_idx + CNT_W'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && keep_hit) begin
            keep_cnt <= keep_cnt + CNT_W'(1);
          end
          if (rd_idx == occ && !pend) begin
            occ   <= keep_cnt;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
      res <= '0;
    end else if (state == ST_FCHK && in_range) begin
      if (!seen) begin
        res.first_seen <= 1'b1;
      end else if (rising) begin
        res.hit_added   <= has_room;
        res.hit_dropped <= !has_room;
      end
    end else if (state == ST_QRUN && pend && keep_hit) begin
      res.slip_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) occ <= CNT_W'(HIT_DEPTH))
    else $error("hit occupancy above store depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRUN) |-> (keep_cnt <= rd_idx))
    else $error("compaction write index overtook read index");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.slip_sum != '0) |->
      (!rsp.first_seen && !rsp.hit_added && !rsp.hit_dropped))
    else $error("query result carries feed flags");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!req_ready && !rsp_valid))
    else $error("request handled during baseline clear");

endmodule
